// ----- src/htt_pkg.sv -----
// Shared types and constants for the hypergeometric tail test block.
`timescale 1ns / 1ps

package htt_pkg;

	localparam int COUNT_MAX_DEF           = 1023;
	localparam int LOG_FACTORIAL_DEPTH_DEF = 4096;

	// field widths
	localparam int CNT_W    = 10;
	localparam int SUM_W    = 11;   // count plus pseudocount
	localparam int ARG_W    = 16;   // signed factorial arguments
	localparam int LOG_W    = 48;   // signed Q.12 log values
	localparam int ENTRY_W  = 40;   // ln(n!) in Q.12
	localparam int PROB_W   = 17;
	localparam int PC_W     = 8;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PSEUDOCOUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMIT_LOW    = 1'd1;

	// Q.30 constants (PROB_ONE is 1.0 in Q.16)
	localparam logic [31:0] Q30_ONE   = 32'd1073741824;
	localparam logic [31:0] LN2_Q30   = 32'd744261118;
	localparam logic [31:0] Q31_TWO   = 32'd2147483648;
	localparam logic [49:0] EXP_LIMIT = 50'd46144189316;   // 62 * ln2 in Q.30
	localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

	localparam int AT_MAX_I = 400;
	localparam int EX_MAX_I = 64;

	typedef struct packed {
		logic       start;
		logic [4:0] msb;     // top quotient bit
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [4:0] {
		ST_FILL_START,
		ST_FILL_LN,
		ST_FILL_ACC,
		ST_IDLE,
		ST_DEN,
		ST_DEN_DONE,
		ST_TERM,
		ST_TERM2,
		ST_TERM3,
		ST_SOFTPLUS,
		ST_LSE,
		ST_FINAL,
		ST_PROB,
		ST_OUT,
		ST_LC_START,
		ST_LC_ISSUE,
		ST_LC_CAP,
		ST_EX_START,
		ST_EX_DIV,
		ST_EX_MUL,
		ST_EX_MDIV,
		ST_EX_MWAIT,
		ST_AT_START,
		ST_AT_S,
		ST_AT_SQ,
		ST_AT_SQ2,
		ST_AT_LOOP,
		ST_AT_DIV
	} state_t;

endpackage

// ----- src/htt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module htt_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/htt_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module htt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  htt_pkg::div_req_t req,
	input  logic [63:0]       dividend,
	input  logic [31:0]       divisor,
	output htt_pkg::div_stat_t stat,
	output logic [31:0]       quotient,
	output logic [63:0]       remainder
);

	logic        busy_q, done_q;
	logic [63:0] rem_q;
	logic [31:0] dvs_q, quo_q;
	logic [4:0]  bit_q;
	logic [63:0] shifted;
	logic        fits;

	assign shifted = 64'(dvs_q) << bit_q;
	assign fits    = rem_q >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= req.msb;
			end else if (busy_q) begin
				if (bit_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q && fits) begin
			rem_q        <= rem_q - shifted;
			quo_q[bit_q] <= 1'b1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- src/hypergeometric_tail_test.sv -----
// One-sided hypergeometric tail test: sequencer around a shared divider and multiplier.
// Reset: arst_n clears control; the block then fills the ln(n!) table (LOG_FACTORIAL_DEPTH entries),
// with item_stall high; registers take writes. Item time is set by the 1-bit-per-cycle divider in
// the exp and atanh series, run once per further k term and for the final exp; one item at a time,
// next accepted once the result is in the output register. A dropped site is taken in idle with no
// result.
`timescale 1ns / 1ps

module hypergeometric_tail_test #(
	parameter int COUNT_MAX           = htt_pkg::COUNT_MAX_DEF,
	parameter int LOG_FACTORIAL_DEPTH = htt_pkg::LOG_FACTORIAL_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [htt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [htt_pkg::PC_W-1:0]          cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [htt_pkg::CNT_W-1:0]         first_methylated,
	input  logic [htt_pkg::CNT_W-1:0]         first_unmethylated,
	input  logic [htt_pkg::CNT_W-1:0]         second_methylated,
	input  logic [htt_pkg::CNT_W-1:0]         second_unmethylated,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [htt_pkg::PROB_W-1:0]        probability,
	output logic                              low_coverage
);

	localparam int AW = $clog2(LOG_FACTORIAL_DEPTH);
	localparam int CW = htt_pkg::CNT_W;
	localparam int SW = htt_pkg::SUM_W;
	localparam int GW = htt_pkg::ARG_W;
	localparam int LW = htt_pkg::LOG_W;
	localparam int EW = htt_pkg::ENTRY_W;

	htt_pkg::state_t state_q, state_d;
	htt_pkg::state_t lc_ret_q, ex_ret_q, at_ret_q;

	// config
	logic [htt_pkg::PC_W-1:0] pc_q;
	logic                     emit_q;

	// table fill
	logic [AW-1:0]  fill_n_q;
	logic [4:0]     fill_e_q;
	logic [36:0]    fill_eln_q;
	logic [63:0]    fill_acc_q, fill_acc_new;
	logic           fill_inc;
	logic [4:0]     fill_e_new;
	logic [31:0]    fill_m;

	// item
	logic [SW-1:0]        ma_q, ua_q, mb_q, ub_q;
	logic                 low_q, has_q;
	logic signed [GW-1:0] ma_s, ua_s, mb_s, ub_s, klo, k_q;
	logic signed [LW-1:0] den_q, t_q, acc_q, hi_q, term_v, sp_v;
	logic [htt_pkg::PROB_W-1:0] prob_q;
	logic [CW-1:0]        fm, fu, sm, su;
	logic                 low_in;

	// log-binomial
	logic signed [GW-1:0] lc_n_q, lc_k_q, lc_arg;
	logic signed [LW-1:0] lc_sum_q, lc_val;
	logic [1:0]           lc_phase_q;
	logic [AW-1:0]        lc_addr;
	logic                 lc_bad;

	// exp(-d)
	logic [LW-1:0] ex_d_q;
	logic [49:0]   ex_dq;
	logic          ex_big;
	logic [5:0]    ex_j_q;
	logic [29:0]   ex_r_q;
	logic [31:0]   ex_sum_q;
	logic [30:0]   ex_term_q, ex_res_q;
	logic [6:0]    ex_i_q;
	logic          ex_exit;

	// 2*atanh(num/den)
	logic [30:0] at_num_q;
	logic [31:0] at_den_q;
	logic [29:0] at_s_q, at_s2_q, at_p_q;
	logic [31:0] at_sum_q;
	logic [32:0] at_res_q;
	logic [8:0]  at_i_q;
	logic        at_exit;

	// shared units
	htt_pkg::div_req_t  div_req;
	htt_pkg::div_stat_t div_stat;
	logic [63:0] div_dividend, div_rem;
	logic [31:0] div_divisor, div_quo;
	logic        mul_en;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p_q;

	// table memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic out_free;

	htt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	htt_ram #(.WIDTH(EW), .DEPTH(LOG_FACTORIAL_DEPTH)) u_lnfact (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (lc_addr),
		.rdata (ram_rdata)
	);

	// input saturation
	assign fm = (int'(first_methylated) > COUNT_MAX) ? CW'(COUNT_MAX) : first_methylated;
	assign fu = (int'(first_unmethylated) > COUNT_MAX) ? CW'(COUNT_MAX) : first_unmethylated;
	assign sm = (int'(second_methylated) > COUNT_MAX) ? CW'(COUNT_MAX) : second_methylated;
	assign su = (int'(second_unmethylated) > COUNT_MAX) ? CW'(COUNT_MAX) : second_unmethylated;
	assign low_in = (fm == '0 && fu == '0) || (sm == '0 && su == '0);

	assign ma_s = signed'(GW'(ma_q));
	assign ua_s = signed'(GW'(ua_q));
	assign mb_s = signed'(GW'(mb_q));
	assign ub_s = signed'(GW'(ub_q));
	assign klo  = (mb_s > ua_s) ? mb_s - ua_s : '0;

	// fill helpers
	assign fill_inc     = 32'(fill_n_q) == (32'd1 << (fill_e_q + 5'd1));
	assign fill_e_new   = fill_inc ? fill_e_q + 5'd1 : fill_e_q;
	assign fill_m       = 32'((64'(fill_n_q) << 30) >> fill_e_new);
	assign fill_acc_new = fill_acc_q + 64'(fill_eln_q) + 64'(at_res_q);

	// log-binomial helpers; negative arguments read entry 0, which holds 0
	always_comb begin
		case (lc_phase_q)
			2'd0:    lc_arg = lc_n_q;
			2'd1:    lc_arg = lc_k_q;
			default: lc_arg = lc_n_q - lc_k_q;
		endcase
		if (lc_arg <= 0) begin
			lc_addr = '0;
		end else if (int'(lc_arg) >= LOG_FACTORIAL_DEPTH) begin
			lc_addr = AW'(LOG_FACTORIAL_DEPTH - 1);
		end else begin
			lc_addr = AW'(lc_arg);
		end
	end
	assign lc_bad = (lc_n_q < 0) || (lc_k_q < 0) || (lc_k_q > lc_n_q);
	assign lc_val = signed'(LW'(ram_rdata));

	assign term_v = t_q + lc_sum_q - den_q;
	assign sp_v   = signed'(LW'((at_res_q + 33'd131072) >> 18));

	assign ex_dq   = {ex_d_q[31:0], 18'd0};
	assign ex_big  = (|ex_d_q[LW-1:32]) || (ex_dq >= htt_pkg::EXP_LIMIT);
	assign ex_exit = (ex_term_q == '0) || (int'(ex_i_q) >= htt_pkg::EX_MAX_I);
	assign at_exit = (at_p_q == '0) || (int'(at_i_q) >= htt_pkg::AT_MAX_I);

	assign out_free = !result_valid || !result_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			htt_pkg::ST_FILL_START: state_d = htt_pkg::ST_FILL_LN;
			htt_pkg::ST_FILL_LN:    state_d = htt_pkg::ST_AT_START;
			htt_pkg::ST_FILL_ACC:
				state_d = (fill_n_q == AW'(LOG_FACTORIAL_DEPTH - 1)) ? htt_pkg::ST_IDLE
				                                                      : htt_pkg::ST_FILL_LN;
			htt_pkg::ST_IDLE:
				if (item_valid && !(low_in && !emit_q)) begin
					state_d = htt_pkg::ST_DEN;
				end
			htt_pkg::ST_DEN:      state_d = htt_pkg::ST_LC_START;
			htt_pkg::ST_DEN_DONE: state_d = htt_pkg::ST_TERM;
			htt_pkg::ST_TERM:
				state_d = (k_q >= mb_s) ? htt_pkg::ST_FINAL : htt_pkg::ST_LC_START;
			htt_pkg::ST_TERM2:    state_d = htt_pkg::ST_LC_START;
			htt_pkg::ST_TERM3:    state_d = has_q ? htt_pkg::ST_EX_START : htt_pkg::ST_TERM;
			htt_pkg::ST_SOFTPLUS: state_d = htt_pkg::ST_AT_START;
			htt_pkg::ST_LSE:      state_d = htt_pkg::ST_TERM;
			htt_pkg::ST_FINAL:
				state_d = (has_q && acc_q < 0) ? htt_pkg::ST_EX_START : htt_pkg::ST_OUT;
			htt_pkg::ST_PROB:     state_d = htt_pkg::ST_OUT;
			htt_pkg::ST_OUT:      state_d = out_free ? htt_pkg::ST_IDLE : htt_pkg::ST_OUT;
			htt_pkg::ST_LC_START: state_d = lc_bad ? lc_ret_q : htt_pkg::ST_LC_ISSUE;
			htt_pkg::ST_LC_ISSUE: state_d = htt_pkg::ST_LC_CAP;
			htt_pkg::ST_LC_CAP:
				state_d = (lc_phase_q == 2'd2) ? lc_ret_q : htt_pkg::ST_LC_ISSUE;
			htt_pkg::ST_EX_START: state_d = ex_big ? ex_ret_q : htt_pkg::ST_EX_DIV;
			htt_pkg::ST_EX_DIV:   state_d = div_stat.done ? htt_pkg::ST_EX_MUL : htt_pkg::ST_EX_DIV;
			htt_pkg::ST_EX_MUL:   state_d = ex_exit ? ex_ret_q : htt_pkg::ST_EX_MDIV;
			htt_pkg::ST_EX_MDIV:  state_d = htt_pkg::ST_EX_MWAIT;
			htt_pkg::ST_EX_MWAIT:
				state_d = div_stat.done ? htt_pkg::ST_EX_MUL : htt_pkg::ST_EX_MWAIT;
			htt_pkg::ST_AT_START: state_d = htt_pkg::ST_AT_S;
			htt_pkg::ST_AT_S:     state_d = div_stat.done ? htt_pkg::ST_AT_SQ : htt_pkg::ST_AT_S;
			htt_pkg::ST_AT_SQ:    state_d = htt_pkg::ST_AT_SQ2;
			htt_pkg::ST_AT_SQ2:   state_d = htt_pkg::ST_AT_LOOP;
			htt_pkg::ST_AT_LOOP:  state_d = at_exit ? at_ret_q : htt_pkg::ST_AT_DIV;
			htt_pkg::ST_AT_DIV:
				state_d = div_stat.done ? htt_pkg::ST_AT_LOOP : htt_pkg::ST_AT_DIV;
			default:              state_d = htt_pkg::ST_FILL_START;
		endcase
	end

	// unit controls
	always_comb begin
		div_req      = '0;
		div_dividend = '0;
		div_divisor  = '0;
		mul_en       = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		ram_we       = 1'b0;
		ram_waddr    = fill_n_q;
		ram_wdata    = EW'((fill_acc_new + 64'd131072) >> 18);
		case (state_q)
			htt_pkg::ST_FILL_START: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = '0;
			end
			htt_pkg::ST_FILL_ACC: ram_we = 1'b1;
			htt_pkg::ST_EX_START: begin
				div_req.start = !ex_big;
				div_req.msb   = 5'd5;
				div_dividend  = 64'(ex_dq);
				div_divisor   = htt_pkg::LN2_Q30;
			end
			htt_pkg::ST_EX_MUL: begin
				mul_en = 1'b1;
				mul_a  = 32'(ex_term_q);
				mul_b  = 32'(ex_r_q);
			end
			htt_pkg::ST_EX_MDIV: begin
				div_req.start = 1'b1;
				div_req.msb   = 5'd30;
				div_dividend  = mul_p_q >> 30;
				div_divisor   = 32'(ex_i_q);
			end
			htt_pkg::ST_AT_START: begin
				div_req.start = 1'b1;
				div_req.msb   = 5'd29;
				div_dividend  = 64'(at_num_q) << 30;
				div_divisor   = at_den_q;
			end
			htt_pkg::ST_AT_SQ: begin
				mul_en = 1'b1;
				mul_a  = 32'(at_s_q);
				mul_b  = 32'(at_s_q);
			end
			htt_pkg::ST_AT_LOOP: begin
				div_req.start = !at_exit;
				div_req.msb   = 5'd30;
				div_dividend  = 64'(at_p_q);
				div_divisor   = 32'(at_i_q);
				mul_en        = 1'b1;
				mul_a         = 32'(at_p_q);
				mul_b         = 32'(at_s2_q);
			end
			default: ;
		endcase
	end

	assign item_stall = state_q != htt_pkg::ST_IDLE;
	assign cfg_ready  = 1'b1;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= htt_pkg::ST_FILL_START;
			pc_q         <= 8'd1;
			emit_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					htt_pkg::CFG_PSEUDOCOUNT: pc_q   <= cfg_data;
					htt_pkg::CFG_EMIT_LOW:    emit_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == htt_pkg::ST_OUT && out_free) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == htt_pkg::ST_OUT && out_free) begin
			probability  <= prob_q;
			low_coverage <= low_q;
		end
		if (mul_en) begin
			mul_p_q <= 64'(mul_a) * 64'(mul_b);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			htt_pkg::ST_FILL_START: begin
				fill_n_q   <= AW'(1);
				fill_e_q   <= '0;
				fill_eln_q <= '0;
				fill_acc_q <= '0;
			end
			htt_pkg::ST_FILL_LN: begin
				fill_e_q <= fill_e_new;
				if (fill_inc) begin
					fill_eln_q <= fill_eln_q + 37'(htt_pkg::LN2_Q30);
				end
				at_num_q <= 31'(fill_m - htt_pkg::Q30_ONE);
				at_den_q <= fill_m + htt_pkg::Q30_ONE;
				at_ret_q <= htt_pkg::ST_FILL_ACC;
			end
			htt_pkg::ST_FILL_ACC: begin
				fill_acc_q <= fill_acc_new;
				fill_n_q   <= fill_n_q + AW'(1);
			end
			htt_pkg::ST_IDLE: begin
				ma_q  <= SW'(sm) + SW'(pc_q);
				ua_q  <= SW'(su) + SW'(pc_q);
				mb_q  <= SW'(fm) + SW'(pc_q);
				ub_q  <= SW'(fu) + SW'(pc_q);
				low_q <= low_in;
			end
			htt_pkg::ST_DEN: begin
				lc_n_q   <= ma_s + ua_s + mb_s + ub_s - GW'(2);
				lc_k_q   <= ma_s + mb_s - GW'(1);
				lc_ret_q <= htt_pkg::ST_DEN_DONE;
			end
			htt_pkg::ST_DEN_DONE: begin
				den_q <= lc_sum_q;
				k_q   <= klo;
				has_q <= 1'b0;
			end
			htt_pkg::ST_TERM: begin
				lc_n_q   <= mb_s + ub_s - GW'(1);
				lc_k_q   <= k_q;
				lc_ret_q <= htt_pkg::ST_TERM2;
			end
			htt_pkg::ST_TERM2: begin
				t_q      <= lc_sum_q;
				lc_n_q   <= ma_s + ua_s - GW'(1);
				lc_k_q   <= ma_s + mb_s - GW'(1) - k_q;
				lc_ret_q <= htt_pkg::ST_TERM3;
			end
			htt_pkg::ST_TERM3: begin
				if (!has_q) begin
					acc_q <= term_v;
					has_q <= 1'b1;
					k_q   <= k_q + GW'(1);
				end else begin
					// log-sum-exp: hi + ln(1 + exp(-(hi - lo)))
					hi_q     <= (acc_q > term_v) ? acc_q : term_v;
					ex_d_q   <= LW'((acc_q > term_v) ? acc_q - term_v : term_v - acc_q);
					ex_ret_q <= htt_pkg::ST_SOFTPLUS;
				end
			end
			htt_pkg::ST_SOFTPLUS: begin
				at_num_q <= ex_res_q;
				at_den_q <= htt_pkg::Q31_TWO + 32'(ex_res_q);
				at_ret_q <= htt_pkg::ST_LSE;
			end
			htt_pkg::ST_LSE: begin
				acc_q <= hi_q + sp_v;
				k_q   <= k_q + GW'(1);
			end
			htt_pkg::ST_FINAL: begin
				if (!has_q) begin
					prob_q <= '0;
				end else if (acc_q >= 0) begin
					prob_q <= htt_pkg::PROB_ONE;
				end else begin
					ex_d_q   <= LW'(-acc_q);
					ex_ret_q <= htt_pkg::ST_PROB;
				end
			end
			htt_pkg::ST_PROB: begin
				if (32'((ex_res_q + 31'd8192) >> 14) > 32'(htt_pkg::PROB_ONE)) begin
					prob_q <= htt_pkg::PROB_ONE;
				end else begin
					prob_q <= htt_pkg::PROB_W'((ex_res_q + 31'd8192) >> 14);
				end
			end
			htt_pkg::ST_LC_START: begin
				lc_sum_q   <= '0;
				lc_phase_q <= '0;
			end
			htt_pkg::ST_LC_CAP: begin
				lc_sum_q   <= (lc_phase_q == 2'd0) ? lc_sum_q + lc_val : lc_sum_q - lc_val;
				lc_phase_q <= lc_phase_q + 2'd1;
			end
			htt_pkg::ST_EX_START: begin
				if (ex_big) begin
					ex_res_q <= '0;
				end
			end
			htt_pkg::ST_EX_DIV: begin
				if (div_stat.done) begin
					ex_j_q    <= div_quo[5:0];
					ex_r_q    <= div_rem[29:0];
					ex_sum_q  <= htt_pkg::Q30_ONE;
					ex_term_q <= 31'(htt_pkg::Q30_ONE);
					ex_i_q    <= 7'd1;
				end
			end
			htt_pkg::ST_EX_MUL: begin
				if (ex_exit) begin
					ex_res_q <= 31'(ex_sum_q >> ex_j_q);
				end
			end
			htt_pkg::ST_EX_MWAIT: begin
				if (div_stat.done) begin
					ex_term_q <= 31'(div_quo);
					ex_sum_q  <= ex_i_q[0] ? ex_sum_q - div_quo : ex_sum_q + div_quo;
					ex_i_q    <= ex_i_q + 7'd1;
				end
			end
			htt_pkg::ST_AT_S: begin
				if (div_stat.done) begin
					at_s_q <= div_quo[29:0];
				end
			end
			htt_pkg::ST_AT_SQ2: begin
				at_s2_q  <= 30'(mul_p_q >> 30);
				at_p_q   <= at_s_q;
				at_sum_q <= '0;
				at_i_q   <= 9'd1;
			end
			htt_pkg::ST_AT_LOOP: begin
				if (at_exit) begin
					at_res_q <= {at_sum_q, 1'b0};
				end
			end
			htt_pkg::ST_AT_DIV: begin
				if (div_stat.done) begin
					at_sum_q <= at_sum_q + div_quo;
					at_p_q   <= 30'(mul_p_q >> 30);
					at_i_q   <= at_i_q + 9'd2;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- src/htt_chk.sv -----
// Port-level checks for the hypergeometric tail test, bound to the top level.
`timescale 1ns / 1ps

module htt_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [htt_pkg::PROB_W-1:0] probability,
	input logic                       low_coverage
);

	// a waiting request stays
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(probability) && $stable(low_coverage))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> probability <= htt_pkg::PROB_ONE)
		else $error("probability above one");

	// a fresh result never follows an accepted item in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared too early");

endmodule

bind hypergeometric_tail_test htt_chk u_htt_chk (.*);
